>>> hdl/ppd_pkg.sv
package ppd_pkg;

    localparam int SIZE_DIGITS  = 10;
    localparam int CHUNK_DIGITS = 4;
    localparam int HLEN_BYTES   = 3;
    localparam int NLEN_BYTES   = 2;

    localparam int SIZE_W  = 34;
    localparam int CHUNK_W = 15;
    localparam int MAG_W   = 14;

    localparam logic [SIZE_W-1:0] SIZE_CAP  = {SIZE_W{1'b1}};
    localparam logic [MAG_W-1:0]  CHUNK_CAP = {MAG_W{1'b1}};

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef enum logic [3:0] {
        PH_HLEN    = 4'd0,
        PH_NLEN    = 4'd1,
        PH_NAME    = 4'd2,
        PH_SIZE    = 4'd3,
        PH_CHUNK   = 4'd4,
        PH_TOTAL   = 4'd5,
        PH_PAD     = 4'd6,
        PH_PAYLOAD = 4'd7,
        PH_DONE    = 4'd8
    } t_phase;

    typedef enum logic [2:0] {
        NS_LEAD  = 3'd0,
        NS_PSIGN = 3'd1,
        NS_NSIGN = 3'd2,
        NS_PDIG  = 3'd3,
        NS_NDIG  = 3'd4,
        NS_PSTOP = 3'd5,
        NS_NSTOP = 3'd6,
        NS_BAD   = 3'd7
    } t_nstat;

    typedef enum logic [1:0] {
        K_NAME    = 2'd0,
        K_META    = 2'd1,
        K_PAYLOAD = 2'd2,
        K_ERROR   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        E_TRUNC  = 2'd0,
        E_NUMBER = 2'd1,
        E_SHORT  = 2'd2
    } t_err;

    typedef struct packed {
        t_kind               kind;
        logic [7:0]          byte_value;
        logic [SIZE_W-1:0]   data_size;
        logic [CHUNK_W-1:0]  chunk_number;
        logic [CHUNK_W-1:0]  chunk_total;
        t_err                error_code;
        logic                last_of_image;
    } t_res;

endpackage

>>> hdl/ppd_intf.sv
interface ppd_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    logic       end_of_image;

    modport source (output valid, output pixel_byte, output end_of_image, input ready);
    modport sink (input valid, input pixel_byte, input end_of_image, output ready);
endinterface

interface ppd_res_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        kind;
    logic [7:0]                        byte_value;
    logic [ppd_pkg::SIZE_W-1:0]        data_size;
    logic signed [ppd_pkg::CHUNK_W-1:0] chunk_number;
    logic signed [ppd_pkg::CHUNK_W-1:0] chunk_total;
    logic [1:0]                        error_code;
    logic                              last_of_image;

    modport source (
        output valid, output kind, output byte_value, output data_size,
        output chunk_number, output chunk_total, output error_code,
        output last_of_image, input ready
    );
    modport sink (
        input valid, input kind, input byte_value, input data_size,
        input chunk_number, input chunk_total, input error_code,
        input last_of_image, output ready
    );
endinterface

>>> hdl/pixel_payload_header_deframer.sv
// throughput: one input beat per cycle, stalling only while the result queue
//   backs up; results leave the 4-entry queue one per cycle when ready is high;
//   a beat is held in the input register and its results in the result queue
// reset: synchronous, active low; clears the parse state and the result queue
module pixel_payload_header_deframer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ppd_pix_if.sink       i_pix,
    ppd_res_if.source     o_res
);
    import ppd_pkg::*;

    // input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_eoi;

    // parse state
    t_phase              r_phase, n_phase;
    logic [15:0]         r_fc, n_fc;
    logic [23:0]         r_hlen, n_hlen;
    logic [15:0]         r_nlen, n_nlen;
    logic [23:0]         r_hbs, n_hbs;
    logic [SIZE_W-1:0]   r_size, n_size;
    logic [CHUNK_W-1:0]  r_chunk, n_chunk;
    logic [CHUNK_W-1:0]  r_total, n_total;
    t_nstat              r_stat, n_stat;
    logic [SIZE_W-1:0]   r_rem, n_rem;

    // result queue
    t_res                r_q [Q_DEPTH];
    logic [Q_AW-1:0]     r_wp, r_rp;
    logic [Q_AW:0]       r_cnt;

    logic proc_fire;
    logic pop;
    logic in_take;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic [CHUNK_W-1:0] sign15(input logic neg,
                                                   input logic [MAG_W-1:0] mag);
        logic [CHUNK_W-1:0] m;
        m = {1'b0, mag};
        return neg ? CHUNK_W'(CHUNK_W'(0) - m) : m;
    endfunction

    assign proc_fire = r_in_vld && (r_cnt <= (Q_AW+1)'(Q_DEPTH - 2));
    assign in_take   = i_pix.valid && i_pix.ready;
    assign i_pix.ready = !r_in_vld || proc_fire;

    // number scanner
    logic              dig, ws;
    logic [3:0]        dval;
    t_nstat            sc_stat;
    logic              sc_load, sc_mac;
    logic [SIZE_W+3:0] size_mac;
    logic [SIZE_W-1:0] size_sat, size_scan;
    logic [MAG_W-1:0]  chk_cur, chk_sat, chk_scan;
    logic [MAG_W+3:0]  chk_mac;
    logic              num_valid, num_neg;

    always_comb begin
        dig     = is_digit(r_in_byte);
        ws      = is_space(r_in_byte);
        dval    = r_in_byte[3:0];
        sc_stat = r_stat;
        sc_load = 1'b0;
        sc_mac  = 1'b0;
        unique case (r_stat)
            NS_LEAD: begin
                if (ws) begin
                    sc_stat = NS_LEAD;
                end else if (r_in_byte == 8'h2B) begin
                    sc_stat = NS_PSIGN;
                end else if (r_in_byte == 8'h2D) begin
                    sc_stat = NS_NSIGN;
                end else if (!dig) begin
                    sc_stat = NS_BAD;
                end else begin
                    sc_stat = NS_PDIG;
                    sc_load = 1'b1;
                end
            end
            NS_PSIGN, NS_NSIGN: begin
                if (!dig) begin
                    sc_stat = NS_BAD;
                end else begin
                    sc_stat = (r_stat == NS_PSIGN) ? NS_PDIG : NS_NDIG;
                    sc_load = 1'b1;
                end
            end
            NS_PDIG, NS_NDIG: begin
                if (!dig) begin
                    sc_stat = (r_stat == NS_PDIG) ? NS_PSTOP : NS_NSTOP;
                end else begin
                    sc_mac = 1'b1;
                end
            end
            default: sc_stat = r_stat;
        endcase

        size_mac  = {4'd0, r_size} * (SIZE_W+4)'(10) + (SIZE_W+4)'(dval);
        size_sat  = (size_mac > {4'd0, SIZE_CAP}) ? SIZE_CAP : size_mac[SIZE_W-1:0];
        size_scan = sc_load ? SIZE_W'(dval) : (sc_mac ? size_sat : r_size);

        chk_cur   = (r_phase == PH_CHUNK) ? r_chunk[MAG_W-1:0] : r_total[MAG_W-1:0];
        chk_mac   = {4'd0, chk_cur} * (MAG_W+4)'(10) + (MAG_W+4)'(dval);
        chk_sat   = (chk_mac > {4'd0, CHUNK_CAP}) ? CHUNK_CAP : chk_mac[MAG_W-1:0];
        chk_scan  = sc_load ? MAG_W'(dval) : (sc_mac ? chk_sat : chk_cur);

        num_valid = (sc_stat == NS_PDIG) || (sc_stat == NS_NDIG) ||
                    (sc_stat == NS_PSTOP) || (sc_stat == NS_NSTOP);
        num_neg   = (sc_stat == NS_NDIG) || (sc_stat == NS_NSTOP);
    end

    // per-beat step
    t_res        main_res, err_res, res0, res1;
    logic        main_v, eoi_err;
    logic [16:0] fc_inc;
    logic [23:0] hbs_inc;
    logic [1:0]  n_push;

    always_comb begin
        n_phase = r_phase;
        n_fc    = r_fc;
        n_hlen  = r_hlen;
        n_nlen  = r_nlen;
        n_hbs   = r_hbs;
        n_size  = r_size;
        n_chunk = r_chunk;
        n_total = r_total;
        n_stat  = r_stat;
        n_rem   = r_rem;
        main_v  = 1'b0;
        main_res = '0;
        eoi_err = 1'b0;
        fc_inc  = {1'b0, r_fc} + 17'd1;
        hbs_inc = r_hbs + 24'd1;

        err_res = '0;
        err_res.kind = K_ERROR;
        err_res.error_code = E_TRUNC;
        err_res.last_of_image = 1'b1;

        if (proc_fire) begin
            unique case (r_phase)
                PH_HLEN: begin
                    n_hlen = {r_hlen[15:0], r_in_byte};
                    n_hbs  = hbs_inc;
                    if (fc_inc >= 17'(HLEN_BYTES)) begin
                        n_fc    = '0;
                        n_phase = PH_NLEN;
                    end else begin
                        n_fc = fc_inc[15:0];
                    end
                end
                PH_NLEN: begin
                    n_nlen = {r_nlen[7:0], r_in_byte};
                    n_hbs  = hbs_inc;
                    if (fc_inc >= 17'(NLEN_BYTES)) begin
                        n_fc    = '0;
                        n_stat  = NS_LEAD;
                        n_size  = '0;
                        n_phase = (n_nlen != 16'd0) ? PH_NAME : PH_SIZE;
                    end else begin
                        n_fc = fc_inc[15:0];
                    end
                end
                PH_NAME: begin
                    main_v = 1'b1;
                    main_res.kind = K_NAME;
                    main_res.byte_value = r_in_byte;
                    n_hbs = hbs_inc;
                    if (fc_inc >= {1'b0, r_nlen}) begin
                        n_fc    = '0;
                        n_phase = PH_SIZE;
                    end else begin
                        n_fc = fc_inc[15:0];
                    end
                end
                PH_SIZE: begin
                    n_stat = sc_stat;
                    n_size = size_scan;
                    n_hbs  = hbs_inc;
                    n_fc   = fc_inc[15:0];
                    if (fc_inc >= 17'(SIZE_DIGITS)) begin
                        n_fc = '0;
                        if (!num_valid || (num_neg && size_scan != '0)) begin
                            main_v = 1'b1;
                            main_res.kind = K_ERROR;
                            main_res.error_code = E_NUMBER;
                            main_res.last_of_image = 1'b1;
                            n_phase = PH_DONE;
                        end else begin
                            if (num_neg) begin
                                n_size = '0;
                            end
                            n_stat  = NS_LEAD;
                            n_chunk = '0;
                            n_phase = PH_CHUNK;
                        end
                    end
                end
                PH_CHUNK, PH_TOTAL: begin
                    n_stat = sc_stat;
                    if (r_phase == PH_CHUNK) begin
                        n_chunk = {1'b0, chk_scan};
                    end else begin
                        n_total = {1'b0, chk_scan};
                    end
                    n_hbs = hbs_inc;
                    n_fc  = fc_inc[15:0];
                    if (fc_inc >= 17'(CHUNK_DIGITS)) begin
                        n_fc = '0;
                        if (!num_valid) begin
                            main_v = 1'b1;
                            main_res.kind = K_ERROR;
                            main_res.error_code = E_NUMBER;
                            main_res.last_of_image = 1'b1;
                            n_phase = PH_DONE;
                        end else if (r_phase == PH_CHUNK) begin
                            n_chunk = sign15(num_neg, chk_scan);
                            n_stat  = NS_LEAD;
                            n_total = '0;
                            n_phase = PH_TOTAL;
                        end else begin
                            n_total = sign15(num_neg, chk_scan);
                            n_stat  = NS_LEAD;
                            if (r_hlen < hbs_inc) begin
                                main_v = 1'b1;
                                main_res.kind = K_ERROR;
                                main_res.error_code = E_SHORT;
                                main_res.last_of_image = 1'b1;
                                n_phase = PH_DONE;
                            end else begin
                                n_phase = PH_PAD;
                            end
                        end
                    end
                end
                PH_PAD: begin
                    n_hbs = hbs_inc;
                end
                PH_PAYLOAD: begin
                    if (r_rem != '0) begin
                        n_rem = r_rem - SIZE_W'(1);
                    end
                    main_v = 1'b1;
                    main_res.kind = K_PAYLOAD;
                    main_res.byte_value = r_in_byte;
                    main_res.last_of_image = (n_rem == '0) || r_in_eoi;
                    if (n_rem == '0) begin
                        n_phase = PH_DONE;
                    end
                end
                default: n_phase = r_phase;
            endcase

            // header complete
            if (n_phase == PH_PAD && n_hbs == n_hlen) begin
                main_v = 1'b1;
                main_res.kind = K_META;
                main_res.data_size = n_size;
                main_res.chunk_number = n_chunk;
                main_res.chunk_total = n_total;
                main_res.last_of_image = (n_size == '0) || r_in_eoi;
                n_rem   = n_size;
                n_phase = (n_size == '0) ? PH_DONE : PH_PAYLOAD;
            end

            if (r_in_eoi) begin
                eoi_err = (n_phase != PH_PAYLOAD) && (n_phase != PH_DONE);
                n_phase = PH_HLEN;
                n_fc    = '0;
                n_hlen  = '0;
                n_nlen  = '0;
                n_hbs   = '0;
                n_size  = '0;
                n_chunk = '0;
                n_total = '0;
                n_stat  = NS_LEAD;
                n_rem   = '0;
            end
        end

        res0   = main_v ? main_res : err_res;
        res1   = err_res;
        n_push = {1'b0, main_v} + {1'b0, eoi_err};
    end

    assign pop = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_pix.ready) begin
            r_in_vld <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_pix.pixel_byte;
            r_in_eoi  <= i_pix.end_of_image;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HLEN;
            r_fc    <= '0;
            r_hlen  <= '0;
            r_nlen  <= '0;
            r_hbs   <= '0;
            r_size  <= '0;
            r_chunk <= '0;
            r_total <= '0;
            r_stat  <= NS_LEAD;
            r_rem   <= '0;
        end else begin
            r_phase <= n_phase;
            r_fc    <= n_fc;
            r_hlen  <= n_hlen;
            r_nlen  <= n_nlen;
            r_hbs   <= n_hbs;
            r_size  <= n_size;
            r_chunk <= n_chunk;
            r_total <= n_total;
            r_stat  <= n_stat;
            r_rem   <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + Q_AW'(n_push);
            if (pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            r_cnt <= r_cnt + (Q_AW+1)'(n_push) - (Q_AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_q[r_wp] <= res0;
        end
        if (n_push == 2'd2) begin
            r_q[r_wp + Q_AW'(1)] <= res1;
        end
    end

    assign o_res.valid         = (r_cnt != '0);
    assign o_res.kind          = r_q[r_rp].kind;
    assign o_res.byte_value    = r_q[r_rp].byte_value;
    assign o_res.data_size     = r_q[r_rp].data_size;
    assign o_res.chunk_number  = r_q[r_rp].chunk_number;
    assign o_res.chunk_total   = r_q[r_rp].chunk_total;
    assign o_res.error_code    = r_q[r_rp].error_code;
    assign o_res.last_of_image = r_q[r_rp].last_of_image;

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (Q_AW+1)'(Q_DEPTH))
        else $error("result queue overflow");

    a_eoi_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire && r_in_eoi |=> r_phase == PH_HLEN && r_hbs == '0)
        else $error("image end did not restart the parser");

    a_payload_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_rem != '0)
        else $error("payload phase with nothing left");

    a_hlen_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HLEN |-> r_fc < 16'(HLEN_BYTES))
        else $error("header length byte count out of range");

endmodule
